// ===== src/depth_update_sequence_gate_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Depth update sequence gate assertion macros
// Shared property forms for the sequence gate checks. They sample on clk and
// are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DEPTH_UPDATE_SEQUENCE_GATE_UNIT_ASSERT_SVH
`define DEPTH_UPDATE_SEQUENCE_GATE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DUSG_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dusg same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DUSG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dusg next-cycle check failed");

`endif

// ===== src/dusg_pkg.sv =====
// ----------------------------------------------------------------------------
// Depth update sequence gate package
// Types, codes and widths shared by the sequence gate modules.
// ----------------------------------------------------------------------------
package dusg_pkg;

    // Width of an update id.
    localparam int ID_W = 64;

    // Sequence rule selection.
    localparam logic POLICY_SPOT    = 1'b0;
    localparam logic POLICY_FUTURES = 1'b1;

    typedef enum logic [1:0] {
        OP_BATCH   = 2'd0,
        OP_INSTALL = 2'd1,
        OP_RESET   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_AWAIT_BASELINE = 2'd0,
        ST_AWAIT_BRIDGE   = 2'd1,
        ST_SYNCED         = 2'd2,
        ST_RESYNC         = 2'd3
    } sync_t;

    typedef enum logic [2:0] {
        D_APPLIED   = 3'd0,
        D_STALE     = 3'd1,
        D_DUP       = 3'd2,
        D_GAP       = 3'd3,
        D_WRONG     = 3'd4,
        D_INSTALLED = 3'd5,
        D_RESET     = 3'd6
    } disp_t;

    typedef enum logic [2:0] {
        G_NONE         = 3'd0,
        G_SPOT_BOOT    = 3'd1,
        G_SPOT_LIVE    = 3'd2,
        G_FUT_RANGE    = 3'd3,
        G_FUT_NOPREV   = 3'd4,
        G_FUT_MISMATCH = 3'd5
    } gap_t;

    // One input event as held in the input register.
    typedef struct packed {
        logic [1:0]      op;
        logic [ID_W-1:0] first_id;
        logic [ID_W-1:0] final_id;
        logic            prev_final_valid;
        logic [ID_W-1:0] prev_final_id;
        logic [ID_W-1:0] baseline_id;
    } item_t;

    // Sequence tracking state.
    typedef struct packed {
        sync_t           sync;
        logic            held_valid;
        logic [ID_W-1:0] held_id;
        gap_t            gap_cause;
    } state_t;

    // One result as held in the output register.
    typedef struct packed {
        disp_t           disposition;
        sync_t           sync_status;
        logic            last_id_valid;
        logic [ID_W-1:0] last_id;
        gap_t            gap_cause;
        gap_t            held_gap_cause;
    } result_t;

endpackage

// ===== src/dusg_in_stage.sv =====
// ----------------------------------------------------------------------------
// Sequence gate input register
// Captures one input transaction and holds it until the judge stage takes it.
// ----------------------------------------------------------------------------
module dusg_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  dusg_pkg::item_t in_item,
    input  logic           drain,
    output logic           stage_valid,
    output dusg_pkg::item_t stage_item
);

    logic            valid_reg;
    logic            valid_next;
    dusg_pkg::item_t item_reg;

    // The register can take a new transaction when empty or emptying now.
    assign in_ready = !valid_reg || drain;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (drain)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

endmodule

// ===== src/dusg_judge.sv =====
// ----------------------------------------------------------------------------
// Sequence gate judge
// Classifies one event against the held state and forms the next state and
// the result.
// ----------------------------------------------------------------------------
module dusg_judge (
    input  dusg_pkg::item_t   item,
    input  dusg_pkg::state_t  cur,
    input  logic              policy,
    output dusg_pkg::state_t  nxt,
    output dusg_pkg::result_t res
);

    logic             final_lt;
    logic             final_eq;
    logic             final_gt;
    logic             first_le;
    logic             first_succ;
    logic             prev_eq;
    logic             boot;
    logic             covered;
    dusg_pkg::disp_t  verdict;
    dusg_pkg::gap_t   why_batch;
    dusg_pkg::disp_t  disp;
    dusg_pkg::gap_t   why;

    // Compares against the held id.
    assign final_lt   = item.final_id < cur.held_id;
    assign final_eq   = item.final_id == cur.held_id;
    assign final_gt   = item.final_id > cur.held_id;
    assign first_le   = item.first_id <= cur.held_id;
    assign first_succ = {1'b0, item.first_id} == ({1'b0, cur.held_id} + 65'd1);
    assign prev_eq    = item.prev_final_id == cur.held_id;
    assign boot       = cur.sync == dusg_pkg::ST_AWAIT_BRIDGE;
    // The successor never exists past the all-ones id; the 65-bit add keeps that.
    assign covered    = first_le || first_succ;

    // Batch verdict under the selected rules.
    always_comb
    begin
        verdict   = dusg_pkg::D_APPLIED;
        why_batch = dusg_pkg::G_NONE;
        if (final_lt)
        begin
            verdict = dusg_pkg::D_STALE;
        end
        else if (policy == dusg_pkg::POLICY_SPOT)
        begin
            if (final_eq)
            begin
                verdict = dusg_pkg::D_DUP;
            end
            else if (!covered)
            begin
                verdict   = dusg_pkg::D_GAP;
                why_batch = boot ? dusg_pkg::G_SPOT_BOOT : dusg_pkg::G_SPOT_LIVE;
            end
        end
        else if (boot)
        begin
            // Futures bootstrap has no duplicate check.
            if (!first_le)
            begin
                verdict   = dusg_pkg::D_GAP;
                why_batch = dusg_pkg::G_FUT_RANGE;
            end
            else if (!item.prev_final_valid)
            begin
                verdict   = dusg_pkg::D_GAP;
                why_batch = dusg_pkg::G_FUT_NOPREV;
            end
        end
        else
        begin
            if (final_eq)
            begin
                verdict = dusg_pkg::D_DUP;
            end
            else if (!item.prev_final_valid)
            begin
                verdict   = dusg_pkg::D_GAP;
                why_batch = dusg_pkg::G_FUT_NOPREV;
            end
            else if (!prev_eq)
            begin
                verdict   = dusg_pkg::D_GAP;
                why_batch = dusg_pkg::G_FUT_MISMATCH;
            end
        end
    end

    // Event handling and next state.
    always_comb
    begin
        nxt  = cur;
        disp = dusg_pkg::D_WRONG;
        why  = dusg_pkg::G_NONE;
        case (dusg_pkg::op_t'(item.op))
            dusg_pkg::OP_BATCH:
            begin
                if (cur.sync == dusg_pkg::ST_AWAIT_BRIDGE || cur.sync == dusg_pkg::ST_SYNCED)
                begin
                    disp = verdict;
                    why  = why_batch;
                    if (verdict == dusg_pkg::D_GAP)
                    begin
                        nxt.gap_cause = why_batch;
                        nxt.sync      = dusg_pkg::ST_RESYNC;
                    end
                    else if (verdict == dusg_pkg::D_APPLIED)
                    begin
                        if (final_gt)
                        begin
                            nxt.held_id = item.final_id;
                        end
                        nxt.sync = dusg_pkg::ST_SYNCED;
                    end
                end
            end
            dusg_pkg::OP_INSTALL:
            begin
                if (cur.sync != dusg_pkg::ST_SYNCED)
                begin
                    nxt.held_id    = item.baseline_id;
                    nxt.held_valid = 1'b1;
                    nxt.sync       = dusg_pkg::ST_AWAIT_BRIDGE;
                    disp           = dusg_pkg::D_INSTALLED;
                end
            end
            dusg_pkg::OP_RESET:
            begin
                nxt.held_id    = '0;
                nxt.held_valid = 1'b0;
                nxt.gap_cause  = dusg_pkg::G_NONE;
                nxt.sync       = dusg_pkg::ST_AWAIT_BASELINE;
                disp           = dusg_pkg::D_RESET;
            end
            default:
            begin
                disp = dusg_pkg::D_WRONG;
            end
        endcase
    end

    // Result reports the state after the event.
    always_comb
    begin
        res.disposition    = disp;
        res.sync_status    = nxt.sync;
        res.last_id_valid  = nxt.held_valid;
        res.last_id        = nxt.held_id;
        res.gap_cause      = why;
        res.held_gap_cause = nxt.gap_cause;
    end

endmodule

// ===== src/dusg_out_stage.sv =====
// ----------------------------------------------------------------------------
// Sequence gate result register
// Holds one result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module dusg_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  dusg_pkg::result_t res_in,
    output logic              can_load,
    output logic              out_valid,
    input  logic              out_ready,
    output dusg_pkg::result_t res_out
);

    logic              valid_reg;
    logic              valid_next;
    dusg_pkg::result_t res_reg;

    // A new result fits when the register is empty or being taken now.
    assign can_load = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

// ===== src/depth_update_sequence_gate_unit.sv =====
// ----------------------------------------------------------------------------
// Depth update sequence gate
// Checks order-book depth update ids against the last applied id and
// reports a disposition and the sync status for every event.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one event per transaction:
//   a depth batch, a baseline install or a reset, selected by op.
//   Output channel (out_valid/out_ready) returns exactly one result per
//   event, in order. Configuration channel (cfg_valid/cfg_ready/cfg_data)
//   writes the policy bit (0 spot, 1 futures); it is always ready. It must be
//   written only while no event is in flight; the block does not enforce it.
//   An accepted event is held in the input register; its result is written
//   to the output register when that register has room.
//   Throughput: one event per cycle while results are taken, set by the
//   combinational judge between the input register and the result register,
//   which also updates the held id, sync status and gap record.
//   Reset: status awaiting baseline, no held id, no recorded gap, policy
//   spot, both registers empty.
//   Stall: a held result keeps its value; the input register still takes
//   one more event, after which in_ready drops until the receiver drains.
// ----------------------------------------------------------------------------
module depth_update_sequence_gate_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [63:0] first_id,
    input  logic [63:0] final_id,
    input  logic        prev_final_valid,
    input  logic [63:0] prev_final_id,
    input  logic [63:0] baseline_id,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  disposition,
    output logic [1:0]  sync_status,
    output logic        last_id_valid,
    output logic [63:0] last_id,
    output logic [2:0]  gap_cause,
    output logic [2:0]  held_gap_cause
);

    logic              policy_reg;
    dusg_pkg::state_t  state_reg;
    dusg_pkg::state_t  state_next;
    dusg_pkg::item_t   in_item;
    dusg_pkg::item_t   stage_item;
    logic              stage_valid;
    logic              can_load;
    logic              advance;
    dusg_pkg::result_t res_comb;
    dusg_pkg::result_t res_out;

    // Policy register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= dusg_pkg::POLICY_SPOT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            policy_reg <= cfg_data;
        end
    end

    // Input transaction capture.
    assign in_item.op               = op;
    assign in_item.first_id         = first_id;
    assign in_item.final_id         = final_id;
    assign in_item.prev_final_valid = prev_final_valid;
    assign in_item.prev_final_id    = prev_final_id;
    assign in_item.baseline_id      = baseline_id;

    dusg_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .drain       (advance),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    // An event moves on when the result register has room.
    assign advance = stage_valid && can_load;

    dusg_judge u_judge (
        .item   (stage_item),
        .cur    (state_reg),
        .policy (policy_reg),
        .nxt    (state_next),
        .res    (res_comb)
    );

    // Sequence state is committed together with the result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.sync       <= dusg_pkg::ST_AWAIT_BASELINE;
            state_reg.held_valid <= 1'b0;
            state_reg.held_id    <= '0;
            state_reg.gap_cause  <= dusg_pkg::G_NONE;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    dusg_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .res_in    (res_comb),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_out   (res_out)
    );

    // Result fields.
    assign disposition    = res_out.disposition;
    assign sync_status    = res_out.sync_status;
    assign last_id_valid  = res_out.last_id_valid;
    assign last_id        = res_out.last_id;
    assign gap_cause      = res_out.gap_cause;
    assign held_gap_cause = res_out.held_gap_cause;

    // Checks.
`include "depth_update_sequence_gate_unit_assert.svh"

    `DUSG_ASSERT_SAME(a_gap_consistent, out_valid && gap_cause != dusg_pkg::G_NONE, disposition == dusg_pkg::D_GAP && sync_status == dusg_pkg::ST_RESYNC && held_gap_cause == gap_cause)
    `DUSG_ASSERT_SAME(a_reset_clears, out_valid && disposition == dusg_pkg::D_RESET, sync_status == dusg_pkg::ST_AWAIT_BASELINE && !last_id_valid && last_id == '0 && held_gap_cause == dusg_pkg::G_NONE)
    `DUSG_ASSERT_SAME(a_applied_synced, out_valid && disposition == dusg_pkg::D_APPLIED, sync_status == dusg_pkg::ST_SYNCED && last_id_valid)
    `DUSG_ASSERT_NEXT(a_stage_holds, stage_valid && out_valid && !out_ready, stage_valid && out_valid)

endmodule
